@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl modules
// each macro expects clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DNSRAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DNSRAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dnsrae_pkg.sv @@
// shared types and constants for the dns response address extractor
// no dependencies
`timescale 1ns / 1ps

package dnsrae_pkg;

  localparam int MaxPacketBytes = 4096;
  localparam int PosW = $clog2(MaxPacketBytes + 1);
  localparam int HeaderBytes = 12;
  localparam int LabelLimit = 127;
  localparam int QuestionFixed = 4;
  localparam int AnswerFixed = 10;
  localparam int TypeA = 1;
  localparam int TypeAaaa = 28;
  localparam int LenA = 4;
  localparam int LenAaaa = 16;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW = $clog2(FifoDepth);
  localparam int FifoCntW = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    KindIpv4 = 2'd0,
    KindIpv6 = 2'd1,
    KindEnd  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StOk    = 3'd0,
    StShort = 3'd1,
    StId    = 3'd2,
    StRcode = 3'd3,
    StEarly = 3'd4
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    status_e     status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

@@ rtl/dns_response_address_extractor_unit.sv @@
// Usage:
//   Input channel in_valid_i/in_ready_o carries one packet byte per item with
//   final_byte_i marking the last byte. Output channel out_valid_o/out_ready_i
//   carries IPv4/IPv6 address items and one end item with parse_status_o and
//   last_of_packet_o set after the final byte.
//   cfg_valid_i/cfg_ready_o writes the expected transaction id; write it
//   while no packet is in flight. cfg_ready_o is always high.
// Flow: an accepted item is held in the input register, then parsed into the
//   result queue; results are taken from it one per cycle while out_ready_i is high.
// Throughput: one byte per cycle while the queue has room; a byte's parse is a
//   single step of counter and phase updates from input register to result queue.
// Stall: results wait in a four-entry queue; the input register holds its byte
//   while the queue has fewer than two free entries, then in_ready_o drops.
// Reset: clears the parse state, the queue and the expected id (zero).
// Depends on dnsrae_pkg, dnsrae_parser and dnsrae_fifo.
`timescale 1ns / 1ps

module dns_response_address_extractor_unit import dnsrae_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_expected_id_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  item_kind_o,
  output logic [63:0] address_high_o,
  output logic [63:0] address_low_o,
  output logic [2:0]  parse_status_o,
  output logic        last_of_packet_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_final_q;
  logic       room;
  logic       consume;
  push_t      push;
  result_t    res0, res1, head;

  assign cfg_ready_o = 1'b1;
  assign consume     = in_valid_q && room;
  assign in_ready_o  = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q  <= data_byte_i;
      in_final_q <= final_byte_i;
    end
  end

  dnsrae_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_id_i    (cfg_expected_id_i),
    .consume_i   (consume),
    .data_byte_i (in_byte_q),
    .final_byte_i(in_final_q),
    .push_o      (push),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  dnsrae_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res0_i (res0),
    .res1_i (res1),
    .room_o (room),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .head_o (head)
  );

  assign item_kind_o      = head.kind;
  assign address_high_o   = head.addr_high;
  assign address_low_o    = head.addr_low;
  assign parse_status_o   = head.status;
  assign last_of_packet_o = head.last;

endmodule

@@ rtl/dnsrae_parser.sv @@
// byte parser: header checks, name skipping, answer walk, address capture
// depends on dnsrae_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dnsrae_parser import dnsrae_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_id_i,
  input  logic        consume_i,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output push_t       push_o,
  output result_t     res0_o,
  output result_t     res1_o
);

  typedef enum logic [2:0] {
    PhHeader, PhName, PhSkip, PhPtr, PhFixed, PhRdata, PhDone, PhStop
  } phase_e;

  typedef enum logic [1:0] {
    RtNone, RtA, RtAaaa
  } rtype_e;

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      held_q, held_d;
  logic [15:0]     qleft_q, qleft_d;
  logic [15:0]     aleft_q, aleft_d;
  logic [7:0]      lbl_q, lbl_d;
  logic [6:0]      guard_q, guard_d;
  logic [3:0]      fidx_q, fidx_d;
  rtype_e          rtype_q, rtype_d;
  logic [15:0]     rdata_q, rdata_d;
  status_e         stop_q, stop_d;
  logic [15:0]     id_q;
  logic [127:0]    shift_q, shift_d;

  logic [15:0] word;
  logic        addr_valid;
  result_t     addr_item;
  result_t     end_item;
  status_e     end_status;

  assign word = {held_q, data_byte_i};

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    held_d     = held_q;
    qleft_d    = qleft_q;
    aleft_d    = aleft_q;
    lbl_d      = lbl_q;
    guard_d    = guard_q;
    fidx_d     = fidx_q;
    rtype_d    = rtype_q;
    rdata_d    = rdata_q;
    stop_d     = stop_q;
    shift_d    = shift_q;
    addr_valid = 1'b0;
    addr_item  = '0;
    end_item   = '0;
    end_status = StOk;

    if (consume_i && (pos_q < PosW'(MaxPacketBytes))) begin
      pos_d = pos_q + PosW'(1);
      case (phase_q)
        PhHeader: begin
          held_d = data_byte_i;
          if (pos_q == PosW'(1) && word != id_q) begin
            phase_d = PhStop;
            stop_d  = StId;
          end else if (pos_q == PosW'(3) && word[3:0] != 4'd0) begin
            phase_d = PhStop;
            stop_d  = StRcode;
          end else if (pos_q == PosW'(5)) begin
            qleft_d = word;
          end else if (pos_q == PosW'(7)) begin
            aleft_d = word;
          end else if (pos_q == PosW'(HeaderBytes - 1)) begin
            if (qleft_q != 16'd0 || aleft_q != 16'd0) begin
              phase_d = PhName;
              guard_d = '0;
              lbl_d   = '0;
            end else begin
              phase_d = PhDone;
            end
          end
        end
        PhName: begin
          if (guard_q >= 7'(LabelLimit)) begin
            phase_d = PhStop;
            stop_d  = StEarly;
          end else begin
            guard_d = guard_q + 7'd1;
            if (data_byte_i == 8'd0) begin
              phase_d = PhFixed;
              fidx_d  = '0;
            end else if (data_byte_i[7:6] == 2'b11) begin
              phase_d = PhPtr;
            end else begin
              lbl_d   = data_byte_i;
              phase_d = PhSkip;
            end
          end
        end
        PhSkip: begin
          lbl_d = lbl_q - 8'd1;
          if (lbl_q == 8'd1) begin
            phase_d = PhName;
          end
        end
        PhPtr: begin
          phase_d = PhFixed;
          fidx_d  = '0;
        end
        PhFixed: begin
          held_d = data_byte_i;
          fidx_d = fidx_q + 4'd1;
          if (qleft_q != 16'd0) begin
            if (fidx_q >= 4'(QuestionFixed - 1)) begin
              qleft_d = qleft_q - 16'd1;
              if (qleft_d != 16'd0 || aleft_q != 16'd0) begin
                phase_d = PhName;
                guard_d = '0;
                lbl_d   = '0;
              end else begin
                phase_d = PhDone;
              end
            end
          end else begin
            if (fidx_q == 4'd1) begin
              if (word == 16'(TypeA)) begin
                rtype_d = RtA;
              end else if (word == 16'(TypeAaaa)) begin
                rtype_d = RtAaaa;
              end else begin
                rtype_d = RtNone;
              end
            end
            if (fidx_q >= 4'(AnswerFixed - 1)) begin
              rdata_d = word;
              if (!((rtype_q == RtA && word == 16'(LenA)) ||
                    (rtype_q == RtAaaa && word == 16'(LenAaaa)))) begin
                rtype_d = RtNone;
              end
              if (word == 16'd0) begin
                aleft_d = aleft_q - 16'd1;
                if (qleft_q != 16'd0 || aleft_d != 16'd0) begin
                  phase_d = PhName;
                  guard_d = '0;
                  lbl_d   = '0;
                end else begin
                  phase_d = PhDone;
                end
              end else begin
                phase_d = PhRdata;
              end
            end
          end
        end
        PhRdata: begin
          shift_d = {shift_q[119:0], data_byte_i};
          rdata_d = rdata_q - 16'd1;
          if (rdata_q == 16'd1) begin
            aleft_d = aleft_q - 16'd1;
            if (qleft_q != 16'd0 || aleft_d != 16'd0) begin
              phase_d = PhName;
              guard_d = '0;
              lbl_d   = '0;
            end else begin
              phase_d = PhDone;
            end
            if (rtype_q == RtA) begin
              addr_valid         = 1'b1;
              addr_item.kind     = KindIpv4;
              addr_item.addr_low = {32'd0, shift_d[31:0]};
            end else if (rtype_q == RtAaaa) begin
              addr_valid          = 1'b1;
              addr_item.kind      = KindIpv6;
              addr_item.addr_high = shift_d[127:64];
              addr_item.addr_low  = shift_d[63:0];
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (pos_d < PosW'(HeaderBytes)) begin
      end_status = StShort;
    end else if (phase_d == PhStop) begin
      end_status = stop_d;
    end else if (phase_d == PhDone) begin
      end_status = StOk;
    end else begin
      end_status = StEarly;
    end
    end_item.kind   = KindEnd;
    end_item.status = end_status;
    end_item.last   = 1'b1;

    // packet end returns the parse to its reset state
    if (consume_i && final_byte_i) begin
      phase_d = PhHeader;
      pos_d   = '0;
      held_d  = '0;
      qleft_d = '0;
      aleft_d = '0;
      lbl_d   = '0;
      guard_d = '0;
      fidx_d  = '0;
      rtype_d = RtNone;
      rdata_d = '0;
      stop_d  = StOk;
    end
  end

  always_comb begin
    push_o.first  = addr_valid || (consume_i && final_byte_i);
    push_o.second = addr_valid && final_byte_i;
    res0_o        = addr_valid ? addr_item : end_item;
    res1_o        = end_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q   <= '0;
      held_q  <= '0;
      qleft_q <= '0;
      aleft_q <= '0;
      lbl_q   <= '0;
      guard_q <= '0;
      fidx_q  <= '0;
      rtype_q <= RtNone;
      rdata_q <= '0;
      stop_q  <= StOk;
      id_q    <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      held_q  <= held_d;
      qleft_q <= qleft_d;
      aleft_q <= aleft_d;
      lbl_q   <= lbl_d;
      guard_q <= guard_d;
      fidx_q  <= fidx_d;
      rtype_q <= rtype_d;
      rdata_q <= rdata_d;
      stop_q  <= stop_d;
      if (cfg_we_i) begin
        id_q <= cfg_id_i;
      end
    end
  end

  // record data bytes only; all bytes of an address are shifted in before it is taken
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  `DNSRAE_ASSERT(a_second_needs_first, !push_o.second || push_o.first, "second push alone")
  `DNSRAE_ASSERT(a_header_pos, phase_q != PhHeader || pos_q < PosW'(HeaderBytes), "header overrun")
  `DNSRAE_ASSERT_NEXT(a_final_clears, consume_i && final_byte_i, phase_q == PhHeader && pos_q == '0, "parse not cleared after final byte")

endmodule

@@ rtl/dnsrae_fifo.sv @@
// result queue taking up to two results per cycle and giving one per cycle while ready_i is high
// depends on dnsrae_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dnsrae_fifo import dnsrae_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  result_t res0_i,
  input  result_t res1_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t head_o
);

  result_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]  wptr_q, rptr_q;
  logic [FifoCntW-1:0]  count_q;
  logic                 pop;
  logic [FifoPtrW-1:0]  wptr_next;

  assign valid_o   = count_q != '0;
  assign pop       = valid_o && ready_i;
  assign head_o    = mem_q[rptr_q];
  assign room_o    = count_q <= FifoCntW'(FifoDepth - 2);
  assign wptr_next = wptr_q + FifoPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wptr_q] <= res0_i;
    end
    if (push_i.second) begin
      mem_q[wptr_next] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + FifoPtrW'(push_i.first) + FifoPtrW'(push_i.second);
      rptr_q  <= rptr_q + FifoPtrW'(pop);
      count_q <= count_q + FifoCntW'(push_i.first) + FifoCntW'(push_i.second)
                 - FifoCntW'(pop);
    end
  end

  `DNSRAE_ASSERT(a_no_overflow, count_q <= FifoCntW'(FifoDepth), "queue overflow")
  `DNSRAE_ASSERT_NEXT(a_pop_drains, pop && !push_i.first, count_q == $past(count_q) - FifoCntW'(1), "pop not counted")

endmodule
